[sv/ucfh_pkg.sv]
// Package for the UART command frame handler: constants, codes and divider port types.
package ucfh_pkg;

  // Frame layout
  localparam int FRAME_BYTES_DEF = 16;
  localparam int HDR_BYTES       = 9;   // only bytes 0..8 are ever decoded

  localparam logic [7:0] SYNC0        = 8'h55;
  localparam logic [7:0] SYNC1        = 8'hAA;
  localparam logic [7:0] CMD_BUTTON   = 8'h01;
  localparam logic [7:0] CMD_SETTINGS = 8'h02;

  localparam logic [7:0] BTN_ENTER  = 8'h00;
  localparam logic [7:0] BTN_SELECT = 8'h01;
  localparam logic [7:0] BTN_RUN    = 8'h02;
  localparam logic [7:0] BTN_RESET  = 8'h03;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_BUTTON   = 2'd1;
  localparam logic [1:0] KIND_SETTINGS = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd3;

  localparam logic [1:0] MENU_SHAPE = 2'd0;
  localparam logic [1:0] MENU_AMPL  = 2'd1;
  localparam logic [1:0] MENU_FREQ  = 2'd2;

  localparam logic [7:0]  SHAPE_MAX = 8'd3;
  localparam logic [15:0] MIN_RATE  = 16'd4;

  // Reset values of the settings
  localparam logic [1:0]  SHAPE_RST  = 2'd3;
  localparam logic [7:0]  AMPL_RST   = 8'd255;
  localparam logic [7:0]  FREQ_RST   = 8'd2;
  localparam logic [15:0] LENGTH_RST = 16'd50;
  localparam logic [15:0] RATE_RST   = 16'd1000;
  localparam logic [15:0] RELOAD_RST = 16'd62500;

  // Timer reload divide: 250000 / rate
  localparam int          DVD_W    = 18;
  localparam logic [17:0] DIVIDEND = 18'd250000;
  localparam int          STEP_W   = 5;

  typedef struct packed {
    logic        start;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

endpackage

[sv/ucfh_div.sv]
// Restoring divider: constant dividend over a 16-bit divisor, one quotient bit per cycle.
module ucfh_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ucfh_pkg::div_req_t req,
  output ucfh_pkg::div_rsp_t rsp
);

  logic                         busy_r;
  logic                         done_r;
  logic [ucfh_pkg::STEP_W-1:0]  step_r;
  logic [ucfh_pkg::DVD_W-1:0]   dvd_r;
  logic [ucfh_pkg::DVD_W-1:0]   quot_r;
  logic [15:0]                  rem_r;
  logic [15:0]                  dsr_r;
  logic [16:0]                  rem_sh;
  logic                         ge;

  assign rem_sh = {rem_r, dvd_r[ucfh_pkg::DVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= ucfh_pkg::STEP_W'(ucfh_pkg::DVD_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      dsr_r  <= req.divisor;
      dvd_r  <= ucfh_pkg::DIVIDEND;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[ucfh_pkg::DVD_W-2:0], 1'b0};
      quot_r <= {quot_r[ucfh_pkg::DVD_W-2:0], ge};
      rem_r  <= ge ? 16'(rem_sh - {1'b0, dsr_r}) : rem_sh[15:0];
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r[15:0];

endmodule

[sv/uart_command_frame_handler.sv]
// Top level of the UART command frame handler: frame assembly, command decode, settings.
//
// Input channel (in_valid/in_ready/in_rx_byte): one received UART byte per word.
// Output channel (out_valid/out_ready/out_*): one result word per input byte,
// carrying the completion flag, the command kind and every setting as it
// stands after that byte.
// A byte that does not finish a settings frame passes through evaluate and
// then loads the output register once it is free, which raises out_valid;
// the next byte is taken only after that load.
// A settings frame with a valid rate runs the restoring divider for
// 250000 / rate, plus the handshake into and out of it, before out_valid
// rises. One byte is in work at a time; in_ready is high only between
// bytes, so the divider sets the worst-case rate.
// The output register holds a finished word while the next byte is taken;
// if the receiver stalls, the following byte completes and then waits.
// Reset (rst_n low, synchronous) clears the frame header bytes and byte
// count and restores the default settings: shape 3, amplitude 255,
// frequency 2, not running, length 50, rate 1000, reload 62500.
module uart_command_frame_handler #(
  parameter int FRAME_BYTES = ucfh_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_complete,
  output logic [1:0]  out_command_kind,
  output logic [1:0]  out_menu_index,
  output logic [1:0]  out_wave_shape,
  output logic [7:0]  out_wave_amplitude,
  output logic [7:0]  out_wave_frequency,
  output logic        out_running,
  output logic [15:0] out_capture_length,
  output logic [15:0] out_rate_value,
  output logic [15:0] out_reload_value,
  output logic        out_rate_error
);

  localparam int CW   = $clog2(FRAME_BYTES + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DIV, S_FIN} state_t;

  state_t       state_r;
  logic [CW-1:0] cnt_r;
  // Only the header bytes 0..8 are decoded, so only they are kept.
  logic [7:0]   hdr_r [ucfh_pkg::HDR_BYTES];

  logic [1:0]   menu_r;
  logic [1:0]   shape_r;
  logic [7:0]   ampl_r;
  logic [7:0]   freq_r;
  logic         run_r;
  logic [15:0]  length_r;
  logic [15:0]  rate_r;
  logic [15:0]  reload_r;

  logic         complete_r;
  logic [1:0]   kind_r;
  logic         err_r;
  logic         div_start_r;

  logic         out_valid_r;
  logic         o_complete_r;
  logic [1:0]   o_kind_r;
  logic [1:0]   o_menu_r;
  logic [1:0]   o_shape_r;
  logic [7:0]   o_ampl_r;
  logic [7:0]   o_freq_r;
  logic         o_run_r;
  logic [15:0]  o_length_r;
  logic [15:0]  o_rate_r;
  logic [15:0]  o_reload_r;
  logic         o_err_r;

  ucfh_pkg::div_req_t div_req;
  ucfh_pkg::div_rsp_t div_rsp;

  logic         frame_hit;
  logic [15:0]  rx_rate;
  logic [15:0]  rx_length;
  logic         out_free;

  assign rx_rate   = {hdr_r[5], hdr_r[6]};
  assign rx_length = {hdr_r[7], hdr_r[8]};
  assign frame_hit = (hdr_r[0] == ucfh_pkg::SYNC0) && (hdr_r[1] == ucfh_pkg::SYNC1)
                  && (CMPW'(cnt_r) == CMPW'(hdr_r[3]));
  assign out_free  = !out_valid_r || out_ready;

  assign div_req.start   = div_start_r;
  assign div_req.divisor = rx_rate;

  ucfh_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // header capture: byte lands at the count it arrived at
  always_ff @(posedge clk) begin
    for (int i = 0; i < ucfh_pkg::HDR_BYTES; i++) begin
      if (!rst_n) begin
        hdr_r[i] <= '0;
      end else if (in_valid && in_ready && (cnt_r == CW'(i))) begin
        hdr_r[i] <= in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      menu_r      <= ucfh_pkg::MENU_SHAPE;
      shape_r     <= ucfh_pkg::SHAPE_RST;
      ampl_r      <= ucfh_pkg::AMPL_RST;
      freq_r      <= ucfh_pkg::FREQ_RST;
      run_r       <= 1'b0;
      length_r    <= ucfh_pkg::LENGTH_RST;
      rate_r      <= ucfh_pkg::RATE_RST;
      reload_r    <= ucfh_pkg::RELOAD_RST;
      complete_r  <= 1'b0;
      kind_r      <= ucfh_pkg::KIND_NONE;
      err_r       <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a new word replaces the old one in the same cycle it is taken
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (frame_hit) begin
            cnt_r      <= '0;
            complete_r <= 1'b1;
            priority if (hdr_r[4] == ucfh_pkg::CMD_BUTTON) begin
              kind_r  <= ucfh_pkg::KIND_BUTTON;
              err_r   <= 1'b0;
              state_r <= S_FIN;
              priority case (hdr_r[5])
                ucfh_pkg::BTN_ENTER: begin
                  priority case (menu_r)
                    ucfh_pkg::MENU_SHAPE: begin
                      if (hdr_r[6] <= ucfh_pkg::SHAPE_MAX) shape_r <= hdr_r[6][1:0];
                    end
                    ucfh_pkg::MENU_AMPL: ampl_r <= hdr_r[6];
                    ucfh_pkg::MENU_FREQ: freq_r <= hdr_r[6];
                    default: ;
                  endcase
                end
                ucfh_pkg::BTN_SELECT: begin
                  menu_r <= (menu_r == ucfh_pkg::MENU_FREQ) ? ucfh_pkg::MENU_SHAPE
                                                            : menu_r + 1'b1;
                end
                ucfh_pkg::BTN_RUN: run_r <= ~run_r;
                ucfh_pkg::BTN_RESET: begin
                  menu_r  <= ucfh_pkg::MENU_SHAPE;
                  shape_r <= '0;
                  ampl_r  <= '0;
                  freq_r  <= '0;
                end
                default: ;
              endcase
            end else if (hdr_r[4] == ucfh_pkg::CMD_SETTINGS) begin
              kind_r <= ucfh_pkg::KIND_SETTINGS;
              if (rx_rate < ucfh_pkg::MIN_RATE) begin
                err_r   <= 1'b1;   // reload would overflow: keep old settings
                state_r <= S_FIN;
              end else begin
                err_r       <= 1'b0;
                div_start_r <= 1'b1;
                state_r     <= S_DIV;
              end
            end else begin
              kind_r  <= ucfh_pkg::KIND_UNKNOWN;
              err_r   <= 1'b0;
              state_r <= S_FIN;
            end
          end else begin
            complete_r <= 1'b0;
            kind_r     <= ucfh_pkg::KIND_NONE;
            err_r      <= 1'b0;
            state_r    <= S_FIN;
            if (cnt_r == CW'(FRAME_BYTES)) begin
              cnt_r <= '0;   // buffer full, wrap
            end
          end
        end
        S_DIV: begin
          div_start_r <= 1'b0;
          if (div_rsp.done) begin
            length_r <= rx_length;
            rate_r   <= rx_rate;
            reload_r <= 16'(~div_rsp.quot + 16'd1);   // 65536 - q, mod 2^16
            state_r  <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      o_complete_r <= complete_r;
      o_kind_r     <= kind_r;
      o_menu_r     <= menu_r;
      o_shape_r    <= shape_r;
      o_ampl_r     <= ampl_r;
      o_freq_r     <= freq_r;
      o_run_r      <= run_r;
      o_length_r   <= length_r;
      o_rate_r     <= rate_r;
      o_reload_r   <= reload_r;
      o_err_r      <= err_r;
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_frame_complete = o_complete_r;
  assign out_command_kind   = o_kind_r;
  assign out_menu_index     = o_menu_r;
  assign out_wave_shape     = o_shape_r;
  assign out_wave_amplitude = o_ampl_r;
  assign out_wave_frequency = o_freq_r;
  assign out_running        = o_run_r;
  assign out_capture_length = o_length_r;
  assign out_rate_value     = o_rate_r;
  assign out_reload_value   = o_reload_r;
  assign out_rate_error     = o_err_r;

`ifndef ASSERT_OFF
  a_kind_iff_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_complete == (out_command_kind != ucfh_pkg::KIND_NONE)))
    else $error("command kind disagrees with frame completion");

  a_err_only_settings: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rate_error) |-> (out_command_kind == ucfh_pkg::KIND_SETTINGS))
    else $error("rate error on a non-settings result");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_r < CW'(FRAME_BYTES)))
    else $error("byte count not wrapped before next byte");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide wait");

  a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> (state_r == S_DIV && !in_ready))
    else $error("divider busy while sequencer is elsewhere");
`endif

endmodule

[tb/testbench.sv]
// Testbench for the UART command frame handler: directed table, random frames, scoreboard.
`timescale 1ns / 100ps

module testbench;

  localparam int FRAME_BYTES = ucfh_pkg::FRAME_BYTES_DEF;
  localparam int N_BYTES     = 1850;   // stimulus stops once this many bytes are in
  localparam int N_DIRECTED  = 28;
  localparam int DRAIN_WAIT  = 40;

  // command byte with no meaning, used to hit the unknown-command decode
  localparam logic [7:0] CMD_SPARE = 8'h07;

  // One result word, as the handler presents it
  typedef struct {
    logic        done;
    logic [1:0]  kind;
    logic [1:0]  menu;
    logic [1:0]  shape;
    logic [7:0]  ampl;
    logic [7:0]  freq;
    logic        run;
    logic [15:0] cap_len;
    logic [15:0] rate;
    logic [15:0] reload;
    logic        err;
  } status_word_t;

  // One row of the directed table; typed rows carry the completion fields by hand
  typedef struct {
    logic [7:0] rx;
    bit         typed;
    logic       done;
    logic [1:0] kind;
    logic       err;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_frame_complete;
  logic [1:0]  out_command_kind;
  logic [1:0]  out_menu_index;
  logic [1:0]  out_wave_shape;
  logic [7:0]  out_wave_amplitude;
  logic [7:0]  out_wave_frequency;
  logic        out_running;
  logic [15:0] out_capture_length;
  logic [15:0] out_rate_value;
  logic [15:0] out_reload_value;
  logic        out_rate_error;

  always #2 clk = ~clk;

  uart_command_frame_handler u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_complete (out_frame_complete),
    .out_command_kind   (out_command_kind),
    .out_menu_index     (out_menu_index),
    .out_wave_shape     (out_wave_shape),
    .out_wave_amplitude (out_wave_amplitude),
    .out_wave_frequency (out_wave_frequency),
    .out_running        (out_running),
    .out_capture_length (out_capture_length),
    .out_rate_value     (out_rate_value),
    .out_reload_value   (out_reload_value),
    .out_rate_error     (out_rate_error)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the handler's state, starting from its reset values.
  // The frame store is all zero after reset, so stale-header reads are defined.
  // ---------------------------------------------------------------------------
  logic [7:0]  rx_frame [FRAME_BYTES] = '{default: 8'h00};
  int          rx_count   = 0;
  logic [1:0]  menu_sel   = ucfh_pkg::MENU_SHAPE;
  logic [1:0]  shape_set  = ucfh_pkg::SHAPE_RST;
  logic [7:0]  ampl_set   = ucfh_pkg::AMPL_RST;
  logic [7:0]  freq_set   = ucfh_pkg::FREQ_RST;
  logic        run_set    = 1'b0;
  logic [15:0] length_set = ucfh_pkg::LENGTH_RST;
  logic [15:0] rate_set   = ucfh_pkg::RATE_RST;
  logic [15:0] reload_set = ucfh_pkg::RELOAD_RST;

  status_word_t expected_words [$];
  int           mismatches     = 0;
  int           bytes_sent     = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;

  // Take one received byte into the shadow state and work out the word it gives.
  function automatic status_word_t step_frame(input logic [7:0] b);
    status_word_t w;
    logic [15:0]  req_rate;
    if (rx_count < FRAME_BYTES) rx_frame[rx_count] = b;
    rx_count++;
    w.done = 1'b0;
    w.kind = ucfh_pkg::KIND_NONE;
    w.err  = 1'b0;
    // the test reads the store as it stands, leftovers from old frames included
    if (rx_frame[0] == ucfh_pkg::SYNC0 && rx_frame[1] == ucfh_pkg::SYNC1
        && rx_count == int'(rx_frame[3])) begin
      rx_count = 0;
      w.done   = 1'b1;
      if (rx_frame[4] == ucfh_pkg::CMD_BUTTON) begin
        w.kind = ucfh_pkg::KIND_BUTTON;
        case (rx_frame[5])
          ucfh_pkg::BTN_ENTER: begin
            if (menu_sel == ucfh_pkg::MENU_SHAPE) begin
              if (rx_frame[6] <= ucfh_pkg::SHAPE_MAX) shape_set = rx_frame[6][1:0];
            end else if (menu_sel == ucfh_pkg::MENU_AMPL) begin
              ampl_set = rx_frame[6];
            end else if (menu_sel == ucfh_pkg::MENU_FREQ) begin
              freq_set = rx_frame[6];
            end
          end
          ucfh_pkg::BTN_SELECT: begin
            menu_sel = (menu_sel == ucfh_pkg::MENU_FREQ) ? ucfh_pkg::MENU_SHAPE
                                                         : menu_sel + 2'd1;
          end
          ucfh_pkg::BTN_RUN: run_set = ~run_set;
          ucfh_pkg::BTN_RESET: begin
            // run flag survives a menu reset
            shape_set = 2'd0;
            ampl_set  = 8'd0;
            freq_set  = 8'd0;
            menu_sel  = ucfh_pkg::MENU_SHAPE;
          end
          default: ;
        endcase
      end else if (rx_frame[4] == ucfh_pkg::CMD_SETTINGS) begin
        w.kind   = ucfh_pkg::KIND_SETTINGS;
        req_rate = {rx_frame[5], rx_frame[6]};
        if (req_rate < ucfh_pkg::MIN_RATE) begin
          w.err = 1'b1;   // reload would overflow: flag it, keep the old settings
        end else begin
          length_set = {rx_frame[7], rx_frame[8]};
          rate_set   = req_rate;
          reload_set = 16'(65536 - 250000 / int'(req_rate));
        end
      end else begin
        w.kind = ucfh_pkg::KIND_UNKNOWN;
      end
    end else if (rx_count >= FRAME_BYTES) begin
      rx_count = 0;   // store full: wrap and overwrite byte 0
    end
    w.menu    = menu_sel;
    w.shape   = shape_set;
    w.ampl    = ampl_set;
    w.freq    = freq_set;
    w.run     = run_set;
    w.cap_len = length_set;
    w.rate    = rate_set;
    w.reload  = reload_set;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Idling phases follow progress through the stimulus:
  // none, sender idle, receiver stalling, both lightly, none again.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input logic done = 1'b0,
                           input logic [1:0] kind = ucfh_pkg::KIND_NONE,
                           input logic err = 1'b0);
    status_word_t w;
    int           phase;
    phase = (bytes_sent * 5) / N_BYTES;
    case (phase)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
      3:       begin send_idle_pct = 20; recv_stall_pct = 20; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    // word accepted at this edge
    w = step_frame(b);
    if (typed) begin
      w.done = done;
      w.kind = kind;
      w.err  = err;
    end
    expected_words.push_back(w);
    bytes_sent++;
  endtask

  // A well-formed frame with random content: mostly minimal length, some padded
  // up to the store size, a few cut short so that leftover bytes get decoded.
  task automatic send_random_frame();
    logic [7:0]  f [FRAME_BYTES];
    logic [15:0] rate;
    int          need;
    int          flen;
    int          pick;
    foreach (f[i]) f[i] = 8'($urandom);
    f[0] = ucfh_pkg::SYNC0;
    f[1] = ucfh_pkg::SYNC1;
    pick = $urandom_range(99);
    if (pick < 45) begin
      f[4] = ucfh_pkg::CMD_BUTTON;
      need = 7;
      f[5] = ($urandom_range(9) < 8) ? 8'($urandom_range(3)) : 8'($urandom);
      // switch values around the shape limit, otherwise anything
      f[6] = $urandom_range(1) ? 8'($urandom_range(5)) : 8'($urandom);
    end else if (pick < 85) begin
      f[4] = ucfh_pkg::CMD_SETTINGS;
      need = 9;
      case ($urandom_range(5))
        0:       rate = 16'($urandom_range(3));                 // rejected
        1:       rate = $urandom_range(1) ? 16'hFFFF : ucfh_pkg::MIN_RATE;
        2:       rate = 16'($urandom_range(300, 4));
        default: rate = 16'($urandom);
      endcase
      {f[5], f[6]} = rate;
    end else begin
      do f[4] = 8'($urandom);
      while (f[4] == ucfh_pkg::CMD_BUTTON || f[4] == ucfh_pkg::CMD_SETTINGS);
      need = 5;
    end
    pick = $urandom_range(9);
    if (pick < 6)      flen = need;
    else if (pick < 9) flen = $urandom_range(FRAME_BYTES, need);
    else               flen = $urandom_range(need - 1, 4);
    f[3] = 8'(flen);
    for (int i = 0; i < flen; i++) send_byte(f[i]);
  endtask

  // Receiver: ready drops at random according to the current phase
  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Scoreboard: every accepted word against the oldest expectation
  always @(posedge clk) begin
    status_word_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        check_field("frame_complete", 16'(want.done),    16'(out_frame_complete));
        check_field("command_kind",   16'(want.kind),    16'(out_command_kind));
        check_field("menu_index",     16'(want.menu),    16'(out_menu_index));
        check_field("wave_shape",     16'(want.shape),   16'(out_wave_shape));
        check_field("wave_amplitude", 16'(want.ampl),    16'(out_wave_amplitude));
        check_field("wave_frequency", 16'(want.freq),    16'(out_wave_frequency));
        check_field("running",        16'(want.run),     16'(out_running));
        check_field("capture_length", want.cap_len,      out_capture_length);
        check_field("rate_value",     want.rate,         out_rate_value);
        check_field("reload_value",   want.reload,       out_reload_value);
        check_field("rate_error",     16'(want.err),     16'(out_rate_error));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed frames. Completion fields are typed where obvious; settings come
  // from the shadow state.
  // ---------------------------------------------------------------------------
  stim_row_t directed [N_DIRECTED] = '{
    // rate 3, just under the floor: flagged, settings left alone
    '{ucfh_pkg::SYNC0,        1'b1, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},   // after reset
    '{ucfh_pkg::SYNC1,        1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'h00,                  1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'h09,                  1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{ucfh_pkg::CMD_SETTINGS, 1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'h00,                  1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'h03,                  1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'hFF,                  1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'hFF,                  1'b1, 1'b1, ucfh_pkg::KIND_SETTINGS, 1'b1},
    // rate 4, the lowest accepted, with the largest record length
    '{ucfh_pkg::SYNC0,        1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{ucfh_pkg::SYNC1,        1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'h00,                  1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'h09,                  1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{ucfh_pkg::CMD_SETTINGS, 1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'h00,                  1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'h04,                  1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'hFF,                  1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'hFF,                  1'b1, 1'b1, ucfh_pkg::KIND_SETTINGS, 1'b0},
    // short button frame: button and switch are leftovers (enter, 4 -> shape kept)
    '{ucfh_pkg::SYNC0,        1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{ucfh_pkg::SYNC1,        1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'h00,                  1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'h05,                  1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{ucfh_pkg::CMD_BUTTON,   1'b1, 1'b1, ucfh_pkg::KIND_BUTTON,   1'b0},
    // unknown command
    '{ucfh_pkg::SYNC0,        1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{ucfh_pkg::SYNC1,        1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'h00,                  1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{8'h05,                  1'b0, 1'b0, ucfh_pkg::KIND_NONE,     1'b0},
    '{CMD_SPARE,              1'b1, 1'b1, ucfh_pkg::KIND_UNKNOWN,  1'b0}
  };

  initial begin
    int pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_byte(directed[i].rx, directed[i].typed, directed[i].done, directed[i].kind,
                directed[i].err);

    // Random part: mostly well-formed frames, some noise and dead headers
    while (bytes_sent < N_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        // pad until the handler's count is back at byte 0
        while (rx_count != 0) send_byte(8'($urandom));
        send_random_frame();
      end else if (pick < 90) begin
        repeat ($urandom_range(20, 1))
          send_byte(($urandom_range(3) == 0) ? ucfh_pkg::SYNC0 : 8'($urandom));
      end else begin
        // header whose length byte can never match the count
        while (rx_count != 0) send_byte(8'($urandom));
        send_byte(ucfh_pkg::SYNC0);
        send_byte(ucfh_pkg::SYNC1);
        send_byte(8'($urandom));
        send_byte($urandom_range(1) ? 8'h00 : 8'($urandom_range(255, FRAME_BYTES + 1)));
        repeat ($urandom_range(14)) send_byte(8'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("uart_command_frame_handler test passed");
    end else begin
      $display("uart_command_frame_handler test failed");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run
  initial begin
    #4000000;
    $display("uart_command_frame_handler test failed");
    $finish;
  end

endmodule
